/* design/spd_pkg.sv */
// Shared constants and controller/datapath interface types for the packet deframer.
package spd_pkg;

    // Largest payload a frame may carry.
    localparam int MAX_PAYLOAD = 32;

    // Width of a length or a received count (holds 0..MAX_PAYLOAD).
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    // Width of a payload buffer address.
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    typedef struct packed {
        logic load_len;
        logic data_wr;
        logic emit_start;
        logic emit_load;
    } t_dp_cmd;

    typedef struct packed {
        logic eq_sync1;
        logic eq_sync2;
        logic len_ok;
        logic data_done;
        logic chk1_ok;
        logic chk2_ok;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

/* design/spd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/spd_datapath.sv */
// Deframer datapath: start-byte registers, running check sums, payload buffer, output register.
module spd_datapath
    import spd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output logic [7:0]           o_payload_byte,
    output logic [5:0]           o_byte_index,
    output logic [6:0]           o_frame_length,
    output logic                 o_last
);

    logic [7:0]        r_sync_first;
    logic [7:0]        r_sync_second;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_count;
    logic [7:0]        r_sum_low;
    logic [7:0]        r_sum_high;
    logic [ADDR_W-1:0] r_idx;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [5:0]        r_out_index;
    logic [6:0]        r_out_length;
    logic              r_out_last;

    logic [LEN_W-1:0]  n_count;
    logic [7:0]        n_sum_low;
    logic [7:0]        n_sum_high;
    logic [LEN_W-1:0]  len_m1;
    logic [7:0]        rd_data;

    assign n_count    = r_count + LEN_W'(1);
    assign n_sum_low  = r_sum_low + i_rx_byte;
    assign n_sum_high = r_sum_high + n_sum_low;
    assign len_m1     = r_len - LEN_W'(1);

    assign o_status.eq_sync1  = (i_rx_byte == r_sync_first);
    assign o_status.eq_sync2  = (i_rx_byte == r_sync_second);
    assign o_status.len_ok    = (i_rx_byte != 8'd0) && (i_rx_byte <= 8'(MAX_PAYLOAD));
    assign o_status.data_done = (n_count >= r_len);
    assign o_status.chk1_ok   = (i_rx_byte == r_sum_low);
    assign o_status.chk2_ok   = (i_rx_byte == r_sum_high);
    assign o_status.emit_last = (LEN_W'(r_idx) == len_m1);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    spd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.data_wr),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_len         <= '0;
            r_count       <= '0;
            r_sum_low     <= '0;
            r_sum_high    <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SYNC_FIRST) begin
                    r_sync_first <= i_cfg_data;
                end else if (i_cfg_index == CFG_SYNC_SECOND) begin
                    r_sync_second <= i_cfg_data;
                end
            end
            if (i_cmd.load_len) begin
                r_len      <= i_rx_byte[LEN_W-1:0];
                r_count    <= '0;
                r_sum_low  <= i_rx_byte;
                r_sum_high <= i_rx_byte;
            end else if (i_cmd.data_wr) begin
                r_count    <= n_count;
                r_sum_low  <= n_sum_low;
                r_sum_high <= n_sum_high;
            end
            if (i_cmd.emit_start) begin
                r_idx <= '0;
            end else if (i_cmd.emit_load) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_byte   <= rd_data;
            r_out_index  <= 6'(r_idx);
            r_out_length <= 7'(r_len);
            r_out_last   <= o_status.emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_index;
    assign o_frame_length = r_out_length;
    assign o_last         = r_out_last;

    // The output register is only reloaded once the item it holds has left.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // Payload writes stay inside the buffer.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.data_wr |-> (r_count < LEN_W'(MAX_PAYLOAD)))
        else $error("payload write beyond buffer");

    // Emitted positions never run past the frame length.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (LEN_W'(r_idx) < r_len))
        else $error("emit index beyond frame length");

endmodule

/* design/spd_ctrl.sv */
// Deframer controller: frame hunt sequence and payload emission sequence.
module spd_ctrl
    import spd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_accept,
    input  t_dp_status i_status,
    output logic       o_rx_ready,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] P_SYNC1     = 3'd0;
    localparam logic [2:0] P_SYNC2     = 3'd1;
    localparam logic [2:0] P_LEN       = 3'd2;
    localparam logic [2:0] P_DATA      = 3'd3;
    localparam logic [2:0] P_CHK1      = 3'd4;
    localparam logic [2:0] P_CHK2      = 3'd5;
    localparam logic [2:0] S_EMIT_RD   = 3'd6;
    localparam logic [2:0] S_EMIT_WAIT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_rx_ready = (r_state != S_EMIT_RD) && (r_state != S_EMIT_WAIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            P_SYNC1: begin
                if (i_rx_accept && i_status.eq_sync1) begin
                    n_state = P_SYNC2;
                end
            end
            P_SYNC2: begin
                if (i_rx_accept) begin
                    n_state = i_status.eq_sync2 ? P_LEN : P_SYNC1;
                end
            end
            P_LEN: begin
                if (i_rx_accept) begin
                    if (i_status.len_ok) begin
                        o_cmd.load_len = 1'b1;
                        n_state        = P_DATA;
                    end else begin
                        n_state = P_SYNC1;
                    end
                end
            end
            P_DATA: begin
                if (i_rx_accept) begin
                    o_cmd.data_wr = 1'b1;
                    if (i_status.data_done) begin
                        n_state = P_CHK1;
                    end
                end
            end
            P_CHK1: begin
                if (i_rx_accept) begin
                    n_state = i_status.chk1_ok ? P_CHK2 : P_SYNC1;
                end
            end
            P_CHK2: begin
                if (i_rx_accept) begin
                    if (i_status.chk2_ok) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT_RD;
                    end else begin
                        n_state = P_SYNC1;
                    end
                end
            end
            S_EMIT_RD: begin
                // The buffer read issued here returns data in the next cycle.
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = i_status.emit_last ? P_SYNC1 : S_EMIT_RD;
                end
            end
            default: begin
                n_state = P_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_SYNC1;
        end else begin
            r_state <= n_state;
        end
    end

    // After the final payload byte is loaded the hunt starts over.
    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_load && i_status.emit_last) |=> (r_state == P_SYNC1))
        else $error("controller did not return to hunt after last byte");

    // A passing second check byte always starts emission.
    a_chk2_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == P_CHK2 && i_rx_accept && i_status.chk2_ok) |=> !o_rx_ready)
        else $error("emission not started after good check");

endmodule

/* design/serial_packet_deframer_unit.sv */
// Serial packet deframer: hunts start bytes, checks the two running sums, emits the payload.
// Throughput: one received byte per cycle while hunting and receiving a frame.
// After a good second check byte the payload buffer (one registered read port) is read
// out a byte at a time, each through a read state and a wait state for a free output
// register, which then loads it as valid; input is stalled during that readout.
// Reset: start bytes return to 0xAA and 0x55, the hunt restarts; the buffer is not cleared.
module serial_packet_deframer_unit
    import spd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_payload_byte,
    output logic [5:0]           o_byte_index,
    output logic [6:0]           o_frame_length,
    output logic                 o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       rx_ready;
    logic       rx_accept;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = !rx_ready;
    assign rx_accept   = i_rx_valid && rx_ready;

    spd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_accept (rx_accept),
        .i_status    (status),
        .o_rx_ready  (rx_ready),
        .o_cmd       (cmd)
    );

    spd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

endmodule
